@@ hw/rtl/json_string_unescape_utf8_core_defines.svh @@
// Assertion macros used by the result register of the string unescaper RTL.
`ifndef JSON_STRING_UNESCAPE_UTF8_CORE_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_CORE_DEFINES_SVH

// Clocked assertion with a reset that disables the check.
`define JSU_ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define JSU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/jsu_pkg.sv @@
// Shared codes, types and functions of the string unescaper.
package jsu_pkg;

  localparam logic [2:0] MODE_NORMAL = 3'd0;
  localparam logic [2:0] MODE_ESC    = 3'd1;
  localparam logic [2:0] MODE_HEX1   = 3'd2;
  localparam logic [2:0] MODE_BSL    = 3'd3;
  localparam logic [2:0] MODE_U      = 3'd4;
  localparam logic [2:0] MODE_HEX2   = 3'd5;

  typedef logic [2:0] status_t;

  localparam status_t ST_OK    = 3'd0;
  localparam status_t ST_QUOTE = 3'd1;
  localparam status_t ST_ESC   = 3'd2;
  localparam status_t ST_HEX   = 3'd3;
  localparam status_t ST_SURR  = 3'd4;
  localparam status_t ST_CTRL  = 3'd5;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;

  // Results caused by one input byte; bytes[0] goes out first.
  typedef struct packed {
    logic [2:0]      cnt;
    logic            is_status;
    status_t         status;
    logic [3:0][7:0] bytes;
  } jsu_group_t;

  // Value of a hex digit in bits 3:0; bit 4 set when the byte is no digit.
  function automatic logic [4:0] hex_value(logic [7:0] b);
    logic [4:0] v;
    v = 5'h10;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = {1'b0, b[3:0]};
    end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
      v = {1'b0, b[3:0] + 4'd9};
    end
    return v;
  endfunction

  function automatic jsu_group_t status_group(status_t st);
    jsu_group_t g;
    g.cnt       = 3'd1;
    g.is_status = 1'b1;
    g.status    = st;
    g.bytes     = '0;
    return g;
  endfunction

  function automatic jsu_group_t byte_group(logic [7:0] b);
    jsu_group_t g;
    g.cnt       = 3'd1;
    g.is_status = 1'b0;
    g.status    = ST_OK;
    g.bytes     = {24'h0, b};
    return g;
  endfunction

  // UTF-8 encoding of a code point of up to 21 bits.
  function automatic jsu_group_t utf8_group(logic [20:0] u);
    jsu_group_t g;
    g.is_status = 1'b0;
    g.status    = ST_OK;
    g.bytes     = '0;
    if (u <= 21'h7F) begin
      g.cnt      = 3'd1;
      g.bytes[0] = {1'b0, u[6:0]};
    end else if (u <= 21'h7FF) begin
      g.cnt      = 3'd2;
      g.bytes[0] = {3'b110, u[10:6]};
      g.bytes[1] = {2'b10, u[5:0]};
    end else if (u <= 21'hFFFF) begin
      g.cnt      = 3'd3;
      g.bytes[0] = {4'b1110, u[15:12]};
      g.bytes[1] = {2'b10, u[11:6]};
      g.bytes[2] = {2'b10, u[5:0]};
    end else begin
      g.cnt      = 3'd4;
      g.bytes[0] = {5'b11110, u[20:18]};
      g.bytes[1] = {2'b10, u[17:12]};
      g.bytes[2] = {2'b10, u[11:6]};
      g.bytes[3] = {2'b10, u[5:0]};
    end
    return g;
  endfunction

endpackage

@@ hw/rtl/json_string_unescape_utf8_core.sv @@
// Output: a result is registered and appears in the cycle after its input byte is accepted.
// Throughput: one byte per cycle while the output is ready; a byte that yields more
// than one result (up to four UTF-8 bytes) holds the input while the result register drains.
// Reset: synchronous, active high; clears the parser state and empties the
// result register.
// Top level of the JSON string unescaper with UTF-8 output.
module json_string_unescape_utf8_core
  import jsu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // in_byte[7:0]
  input  logic        s_tuser,   // first_of_string
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // out_byte[7:0], status[10:8], zero[15:11]
  output logic        m_tuser,   // is_status
  output logic        m_tlast    // last
);

  jsu_group_t grp;
  logic       take;

  assign take = s_tvalid && s_tready;

  jsu_decode u_decode (
    .clk             (clk),
    .rst             (rst),
    .take            (take),
    .in_byte         (s_tdata),
    .first_of_string (s_tuser),
    .grp             (grp)
  );

  jsu_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (take),
    .grp_in   (grp),
    .ready    (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

@@ hw/rtl/jsu_decode.sv @@
// Escape decoder: parser state registers and the result group of one byte.
module jsu_decode
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] in_byte,
  input  logic       first_of_string,
  output jsu_group_t grp
);

  logic [2:0]  mode, mode_cur, mode_next;
  logic [1:0]  hex_count, hex_count_cur, hex_count_next;
  logic [15:0] code_value, code_value_cur, code_value_next;
  logic [9:0]  high_surrogate, high_surrogate_cur, high_surrogate_next;
  logic        halted, halted_cur, halted_next;

  logic [4:0]  digit;
  logic [15:0] code_shift;
  logic [20:0] pair_cp;

  assign mode_cur           = first_of_string ? MODE_NORMAL : mode;
  assign hex_count_cur      = first_of_string ? 2'd0 : hex_count;
  assign code_value_cur     = first_of_string ? 16'd0 : code_value;
  assign high_surrogate_cur = first_of_string ? 10'd0 : high_surrogate;
  assign halted_cur         = first_of_string ? 1'b0 : halted;

  assign digit      = hex_value(in_byte);
  assign code_shift = {code_value_cur[11:0], digit[3:0]};
  assign pair_cp    = {1'b0, high_surrogate_cur, code_shift[9:0]} + 21'h10000;

  always_comb begin
    mode_next           = mode_cur;
    hex_count_next      = hex_count_cur;
    code_value_next     = code_value_cur;
    high_surrogate_next = high_surrogate_cur;
    halted_next         = halted_cur;
    grp                 = '0;
    if (!halted_cur) begin
      unique case (mode_cur)
        MODE_ESC: begin
          mode_next = MODE_NORMAL;
          unique case (in_byte)
            CH_U: begin
              mode_next       = MODE_HEX1;
              hex_count_next  = 2'd0;
              code_value_next = 16'd0;
            end
            CH_QUOTE: grp = byte_group(CH_QUOTE);
            CH_BSL:   grp = byte_group(CH_BSL);
            CH_SLASH: grp = byte_group(CH_SLASH);
            CH_B:     grp = byte_group(8'h08);
            CH_F:     grp = byte_group(8'h0C);
            CH_N:     grp = byte_group(8'h0A);
            CH_R:     grp = byte_group(8'h0D);
            CH_T:     grp = byte_group(8'h09);
            default: begin
              grp         = status_group(ST_ESC);
              halted_next = 1'b1;
            end
          endcase
        end
        MODE_HEX1, MODE_HEX2: begin
          if (digit[4]) begin
            grp         = status_group(ST_HEX);
            halted_next = 1'b1;
            mode_next   = MODE_NORMAL;
          end else begin
            code_value_next = code_shift;
            if (hex_count_cur != 2'd3) begin
              hex_count_next = hex_count_cur + 2'd1;
            end else begin
              hex_count_next = 2'd0;
              if (mode_cur == MODE_HEX1) begin
                if (code_shift[15:10] == 6'b110110) begin
                  high_surrogate_next = code_shift[9:0];
                  mode_next           = MODE_BSL;
                end else begin
                  mode_next = MODE_NORMAL;
                  grp       = utf8_group({5'd0, code_shift});
                end
              end else if (code_shift[15:10] != 6'b110111) begin
                grp         = status_group(ST_SURR);
                halted_next = 1'b1;
                mode_next   = MODE_NORMAL;
              end else begin
                mode_next = MODE_NORMAL;
                grp       = utf8_group(pair_cp);
              end
            end
          end
        end
        MODE_BSL: begin
          if (in_byte == CH_BSL) begin
            mode_next = MODE_U;
          end else begin
            grp         = status_group(ST_SURR);
            halted_next = 1'b1;
            mode_next   = MODE_NORMAL;
          end
        end
        MODE_U: begin
          if (in_byte == CH_U) begin
            mode_next       = MODE_HEX2;
            hex_count_next  = 2'd0;
            code_value_next = 16'd0;
          end else begin
            grp         = status_group(ST_SURR);
            halted_next = 1'b1;
            mode_next   = MODE_NORMAL;
          end
        end
        default: begin
          mode_next = MODE_NORMAL;
          priority if (in_byte == CH_QUOTE) begin
            grp         = status_group(ST_OK);
            halted_next = 1'b1;
          end else if (in_byte == CH_BSL) begin
            mode_next = MODE_ESC;
          end else if (in_byte == 8'h00) begin
            grp         = status_group(ST_QUOTE);
            halted_next = 1'b1;
          end else if (in_byte < 8'h20) begin
            grp         = status_group(ST_CTRL);
            halted_next = 1'b1;
          end else begin
            grp = byte_group(in_byte);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_NORMAL;
      hex_count      <= 2'd0;
      code_value     <= 16'd0;
      high_surrogate <= 10'd0;
      halted         <= 1'b0;
    end else if (take) begin
      mode           <= mode_next;
      hex_count      <= hex_count_next;
      code_value     <= code_value_next;
      high_surrogate <= high_surrogate_next;
      halted         <= halted_next;
    end
  end

endmodule

@@ hw/rtl/jsu_emit.sv @@
// Result register that sends the bytes of one group as single transactions.
`include "json_string_unescape_utf8_core_defines.svh"

module jsu_emit
  import jsu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  jsu_group_t  grp_in,
  output logic        ready,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // out_byte[7:0], status[10:8], zero[15:11]
  output logic        m_tuser,  // is_status
  output logic        m_tlast
);

  logic [2:0]      cnt, cnt_next;
  logic [1:0]      idx, idx_next;
  logic            is_status;
  status_t         status;
  logic [3:0][7:0] bytes;
  logic            at_last;
  logic            out_take;

  assign at_last  = ({1'b0, idx} == (cnt - 3'd1));
  assign out_take = m_tvalid && m_tready;
  assign ready    = (cnt == 3'd0) || (m_tready && at_last);

  assign m_tvalid = (cnt != 3'd0);
  assign m_tdata  = {5'd0, status, bytes[idx]};
  assign m_tuser  = is_status;
  assign m_tlast  = at_last;

  always_comb begin
    cnt_next = cnt;
    idx_next = idx;
    if (load) begin
      cnt_next = grp_in.cnt;
      idx_next = 2'd0;
    end else if (out_take) begin
      if (at_last) begin
        cnt_next = 3'd0;
      end else begin
        idx_next = idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 3'd0;
      idx <= 2'd0;
    end else begin
      cnt <= cnt_next;
      idx <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      is_status <= grp_in.is_status;
      status    <= grp_in.status;
      bytes     <= grp_in.bytes;
    end
  end

  `JSU_ASSERT_CLK(a_status_single, clk, rst,
                  (m_tvalid && is_status) |-> (cnt == 3'd1),
                  "status group holds more than one transaction")
  `JSU_ASSERT_CLK(a_idx_in_group, clk, rst, m_tvalid |-> ({1'b0, idx} < cnt),
                  "byte index beyond group")
  `JSU_ASSERT_CLK(a_data_no_status, clk, rst,
                  (m_tvalid && !m_tuser) |-> (m_tdata[10:8] == ST_OK),
                  "data transaction carries a status")
  `JSU_ASSERT_ALWAYS(a_group_size, clk, rst || (cnt <= 3'd4), "group count above four")

endmodule
